### design/hmtv_pkg.sv
`timescale 1ns / 1ps

package hmtv_pkg;

    // byte classes, decided in the front part
    localparam logic [2:0] CL_OTHER     = 3'd0;
    localparam logic [2:0] CL_NEWLINE   = 3'd1;
    localparam logic [2:0] CL_SPACE     = 3'd2;
    localparam logic [2:0] CL_MINUS     = 3'd3;
    localparam logic [2:0] CL_DIGIT     = 3'd4;
    localparam logic [2:0] CL_COMMA     = 3'd5;
    localparam logic [2:0] CL_LOWX      = 3'd6;
    localparam logic [2:0] CL_HEXLETTER = 3'd7;

    typedef struct packed {
        logic [2:0] cls;
        logic [3:0] dval;
        logic       has_char;
        logic       eof;
    } t_item;

endpackage

### design/height_map_text_validator.sv
`timescale 1ns / 1ps

// Checks a text height map one byte per item and, on the item marked end of file,
// gives one result: the verdict, the token count of the first line and the line count.
// A byte item is taken every cycle while the two-entry queue has room; the front
// classifies it into that queue, the back token state machine consumes one entry per
// cycle and registers a result when it pops an end-of-file entry. Only an end-of-file
// item waits, and only while the previous result sits in the output register untaken.
// Token and line counts run COUNT_BITS wide; going past that range flags the map bad.
module height_map_text_validator
    import hmtv_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_code,
    input  logic        i_has_char,
    input  logic        i_end_of_file,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_map_ok,
    output logic [15:0] o_tokens_per_line,
    output logic [15:0] o_line_count
);

    logic  q_valid;
    t_item q_item;
    logic  pop;

    hmtv_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_code   (i_char_code),
        .i_has_char    (i_has_char),
        .i_end_of_file (i_end_of_file),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_pop         (pop)
    );

    hmtv_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_q_valid         (q_valid),
        .i_q_item          (q_item),
        .o_pop             (pop),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_map_ok          (o_map_ok),
        .o_tokens_per_line (o_tokens_per_line),
        .o_line_count      (o_line_count)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> q_valid)
        else $error("queue popped while empty");

    a_bad_map_no_width: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_map_ok) |-> (o_tokens_per_line == 16'd0))
        else $error("invalid map reports a width");

    a_result_from_eof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(pop && q_item.eof))
        else $error("result without end-of-file item");
`endif

endmodule

### design/hmtv_front.sv
`timescale 1ns / 1ps

module hmtv_front
    import hmtv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_char_code,
    input  logic       i_has_char,
    input  logic       i_end_of_file,
    output logic       o_q_valid,
    output t_item      o_q_item,
    input  logic       i_pop
);

    t_item      r_q [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       push;
    t_item      cls_item;

    always_comb begin
        cls_item.cls      = CL_OTHER;
        cls_item.dval     = 4'd0;
        cls_item.has_char = i_has_char;
        cls_item.eof      = i_end_of_file;
        if (i_char_code >= 8'h30 && i_char_code <= 8'h39) begin
            cls_item.cls  = CL_DIGIT;
            cls_item.dval = 4'(i_char_code - 8'h30);
        end else if ((i_char_code >= 8'h61 && i_char_code <= 8'h66) ||
                     (i_char_code >= 8'h41 && i_char_code <= 8'h46)) begin
            cls_item.cls = CL_HEXLETTER;
        end else begin
            case (i_char_code)
                8'h0A: cls_item.cls = CL_NEWLINE;
                8'h20: cls_item.cls = CL_SPACE;
                8'h2D: cls_item.cls = CL_MINUS;
                8'h2C: cls_item.cls = CL_COMMA;
                8'h78: cls_item.cls = CL_LOWX;
                default: cls_item.cls = CL_OTHER;
            endcase
        end
    end

    assign o_ready   = (r_cnt != 2'd2);
    assign push      = i_valid && o_ready;
    assign o_q_valid = (r_cnt != 2'd0);
    assign o_q_item  = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr] <= cls_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end

endmodule

### design/hmtv_back.sv
`timescale 1ns / 1ps

module hmtv_back
    import hmtv_pkg::*;
#(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_item       i_q_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_map_ok,
    output logic [15:0] o_tokens_per_line,
    output logic [15:0] o_line_count
);

    localparam logic [2:0] PH_BETWEEN = 3'd0;
    localparam logic [2:0] PH_NUMBER  = 3'd1;
    localparam logic [2:0] PH_COMMA   = 3'd2;
    localparam logic [2:0] PH_COLOUR  = 3'd3;
    localparam logic [2:0] PH_IGNORE  = 3'd4;

    logic [2:0]            r_phase, n_phase;
    logic [31:0]           r_mag, n_mag;
    logic                  r_neg, n_neg;
    logic                  r_ds, n_ds;
    logic                  r_lz, n_lz;
    logic [3:0]            r_hex, n_hex;
    logic [COUNT_BITS-1:0] r_first, n_first;
    logic [COUNT_BITS-1:0] r_cur, n_cur;
    logic [COUNT_BITS-1:0] r_lines, n_lines;
    logic                  r_err, n_err;
    logic                  r_open, n_open;
    logic                  r_out_valid, n_out_valid;
    logic                  r_map_ok, n_map_ok;
    logic [15:0]           r_tpl, n_tpl;
    logic [15:0]           r_lc, n_lc;

    logic [2:0]  ph;
    logic        take;
    logic        is_nl;
    logic        is_sp;
    logic        tok_end;
    logic        line_end;
    logic        ok;
    logic [35:0] mag_x10;

    // magnitude * 10 + digit as shift-add
    assign mag_x10 = ({4'd0, r_mag} << 3) + ({4'd0, r_mag} << 1) + {32'd0, i_q_item.dval};

    assign o_pop = i_q_valid && !(i_q_item.eof && r_out_valid && !i_ready);

    always_comb begin
        n_phase     = r_phase;
        n_mag       = r_mag;
        n_neg       = r_neg;
        n_ds        = r_ds;
        n_lz        = r_lz;
        n_hex       = r_hex;
        n_first     = r_first;
        n_cur       = r_cur;
        n_lines     = r_lines;
        n_err       = r_err;
        n_open      = r_open;
        n_out_valid = r_out_valid && !i_ready;
        n_map_ok    = r_map_ok;
        n_tpl       = r_tpl;
        n_lc        = r_lc;
        ph          = r_phase;
        take        = i_q_item.has_char && !r_err;
        is_nl       = (i_q_item.cls == CL_NEWLINE);
        is_sp       = (i_q_item.cls == CL_SPACE);
        tok_end     = 1'b0;
        line_end    = 1'b0;
        ok          = 1'b0;

        if (o_pop) begin
            // any taken byte but a newline opens the line; bytes other than a space feed the token
            if (take && !is_nl) begin
                n_open = 1'b1;
                if (!is_sp) begin
                    ph = (r_phase == PH_BETWEEN) ? PH_NUMBER : r_phase;
                    if (ph == PH_COMMA && i_q_item.cls != CL_COMMA) begin
                        ph = PH_COLOUR;
                    end
                    n_phase = ph;
                    case (ph)
                        PH_NUMBER: begin
                            if (i_q_item.cls == CL_MINUS && !r_ds && !r_neg) begin
                                n_neg = 1'b1;
                            end else if (i_q_item.cls == CL_DIGIT) begin
                                if (r_ds && r_lz) begin
                                    n_err = 1'b1;
                                end else begin
                                    if (!r_ds && i_q_item.dval == 4'd0) begin
                                        n_lz = 1'b1;
                                    end
                                    n_ds = 1'b1;
                                    if (mag_x10 > 36'h080000000) begin
                                        n_err = 1'b1;
                                    end else begin
                                        n_mag = mag_x10[31:0];
                                    end
                                end
                            end else if (i_q_item.cls == CL_COMMA) begin
                                if (!r_ds || (r_neg && r_mag == 32'd0) ||
                                    (!r_neg && r_mag > 32'h7FFFFFFF)) begin
                                    n_err = 1'b1;
                                end
                                n_phase = PH_COMMA;
                            end else begin
                                n_err = 1'b1;
                            end
                        end
                        PH_COLOUR: begin
                            if (i_q_item.cls == CL_COMMA) begin
                                if (r_hex != 4'd4 && r_hex != 4'd6 && r_hex != 4'd8) begin
                                    n_err = 1'b1;
                                end
                                n_phase = PH_IGNORE;
                            end else if (r_hex >= 4'd8 ||
                                         (r_hex == 4'd0 && !(i_q_item.cls == CL_DIGIT &&
                                                             i_q_item.dval == 4'd0)) ||
                                         (r_hex == 4'd1 && i_q_item.cls != CL_LOWX) ||
                                         (r_hex >= 4'd2 && i_q_item.cls != CL_DIGIT &&
                                          i_q_item.cls != CL_HEXLETTER)) begin
                                n_err = 1'b1;
                            end else begin
                                n_hex = r_hex + 4'd1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            // an open last line closes at end of file
            line_end = (take && is_nl) || (i_q_item.eof && n_open && !n_err);
            tok_end  = (take && is_sp) || line_end;

            if (tok_end && n_phase != PH_BETWEEN) begin
                if (n_phase == PH_NUMBER) begin
                    if (!n_ds || (n_neg && n_mag == 32'd0) ||
                        (!n_neg && n_mag > 32'h7FFFFFFF)) begin
                        n_err = 1'b1;
                    end
                end else if (n_phase == PH_COLOUR && n_hex != 4'd4 &&
                             n_hex != 4'd6 && n_hex != 4'd8) begin
                    n_err = 1'b1;
                end
                if (!n_err) begin
                    if (&n_cur) begin
                        n_err = 1'b1;
                    end else begin
                        n_cur = n_cur + 1'b1;
                    end
                end
                n_phase = PH_BETWEEN;
                n_mag   = 32'd0;
                n_neg   = 1'b0;
                n_ds    = 1'b0;
                n_lz    = 1'b0;
                n_hex   = 4'd0;
            end

            if (line_end) begin
                if (!n_err) begin
                    if (n_lines == '0) begin
                        n_first = n_cur;
                    end else if (n_cur != n_first) begin
                        n_err = 1'b1;
                    end
                end
                if (!n_err) begin
                    if (&n_lines) begin
                        n_err = 1'b1;
                    end else begin
                        n_lines = n_lines + 1'b1;
                    end
                end
                n_cur  = '0;
                n_open = 1'b0;
            end

            if (i_q_item.eof) begin
                ok          = !n_err && (n_lines != '0) && (n_first != '0);
                n_out_valid = 1'b1;
                n_map_ok    = ok;
                n_tpl       = ok ? 16'(n_first) : 16'd0;
                n_lc        = 16'(n_lines);
                n_phase     = PH_BETWEEN;
                n_mag       = 32'd0;
                n_neg       = 1'b0;
                n_ds        = 1'b0;
                n_lz        = 1'b0;
                n_hex       = 4'd0;
                n_first     = '0;
                n_cur       = '0;
                n_lines     = '0;
                n_err       = 1'b0;
                n_open      = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BETWEEN;
            r_mag       <= 32'd0;
            r_neg       <= 1'b0;
            r_ds        <= 1'b0;
            r_lz        <= 1'b0;
            r_hex       <= 4'd0;
            r_first     <= '0;
            r_cur       <= '0;
            r_lines     <= '0;
            r_err       <= 1'b0;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_mag       <= n_mag;
            r_neg       <= n_neg;
            r_ds        <= n_ds;
            r_lz        <= n_lz;
            r_hex       <= n_hex;
            r_first     <= n_first;
            r_cur       <= n_cur;
            r_lines     <= n_lines;
            r_err       <= n_err;
            r_open      <= n_open;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_map_ok <= n_map_ok;
        r_tpl    <= n_tpl;
        r_lc     <= n_lc;
    end

    assign o_valid           = r_out_valid;
    assign o_map_ok          = r_map_ok;
    assign o_tokens_per_line = r_tpl;
    assign o_line_count      = r_lc;

endmodule

### test/height_map_text_validator_tb.sv
`timescale 1ns / 1ps

module height_map_text_validator_tb;

    localparam int unsigned CNT_MAX = (1 << 16) - 1;
    localparam int HOLD_CYCLES = 300;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_X     = 8'h78;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    typedef enum logic [2:0] {
        TP_GAP,
        TP_NUM,
        TP_COMMA,
        TP_COLOUR,
        TP_SKIP
    } t_tok_phase;

    typedef struct packed {
        logic [7:0] code;
        logic       has;
        logic       eof;
    } t_byte_item;

    typedef struct packed {
        logic        ok;
        logic [15:0] tpl;
        logic [15:0] lines;
    } t_verdict;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [7:0]  i_char_code = 8'd0;
    logic        i_has_char = 1'b0;
    logic        i_end_of_file = 1'b0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic        o_map_ok;
    logic [15:0] o_tokens_per_line;
    logic [15:0] o_line_count;

    height_map_text_validator dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_char_code       (i_char_code),
        .i_has_char        (i_has_char),
        .i_end_of_file     (i_end_of_file),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_map_ok          (o_map_ok),
        .o_tokens_per_line (o_tokens_per_line),
        .o_line_count      (o_line_count)
    );

    always #5 i_clk = ~i_clk;

    t_byte_item  pending_q[$];
    t_verdict    verdict_q[$];
    logic [7:0]  text_q[$];

    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;
    int hold_left = 0;
    int errors = 0;
    int results_seen = 0;
    int items_accepted = 0;
    int bytes_queued = 0;
    int texts_queued = 0;

    // predictor state
    t_tok_phase  pr_phase;
    logic [31:0] pr_mag;
    logic        pr_neg;
    logic        pr_dig;
    logic        pr_lz;
    int unsigned pr_hex;
    int unsigned pr_first;
    int unsigned pr_cur;
    int unsigned pr_lines;
    logic        pr_err;
    logic        pr_open;

    task automatic flag(string msg);
        $display("mismatch at %0t: %s", $time, msg);
        errors++;
    endtask

    function automatic void tok_clear();
        pr_phase = TP_GAP;
        pr_mag = 32'd0;
        pr_neg = 1'b0;
        pr_dig = 1'b0;
        pr_lz = 1'b0;
        pr_hex = 0;
    endfunction

    function automatic void map_clear();
        tok_clear();
        pr_first = 0;
        pr_cur = 0;
        pr_lines = 0;
        pr_err = 1'b0;
        pr_open = 1'b0;
    endfunction

    function automatic bit is_hex(logic [7:0] c);
        return (c >= CH_ZERO && c <= CH_NINE) || (c >= CH_LA && c <= CH_LF) ||
               (c >= CH_UA && c <= CH_UF);
    endfunction

    // colour length includes the 0x prefix
    function automatic bit colour_len_bad(int unsigned n);
        return !(n == 4 || n == 6 || n == 8);
    endfunction

    function automatic void num_check();
        if (!pr_dig || (pr_neg && pr_mag == 32'd0) || (!pr_neg && pr_mag > 32'h7FFF_FFFF)) begin
            pr_err = 1'b1;
        end
    endfunction

    function automatic void tok_close();
        if (pr_phase == TP_GAP) begin
            return;
        end
        if (pr_phase == TP_NUM) begin
            num_check();
        end else if (pr_phase == TP_COLOUR && colour_len_bad(pr_hex)) begin
            pr_err = 1'b1;
        end
        if (!pr_err) begin
            if (pr_cur >= CNT_MAX) begin
                pr_err = 1'b1;
            end else begin
                pr_cur++;
            end
        end
        tok_clear();
    endfunction

    function automatic void line_close();
        tok_close();
        if (!pr_err) begin
            if (pr_lines == 0) begin
                pr_first = pr_cur;
            end else if (pr_cur != pr_first) begin
                pr_err = 1'b1;
            end
        end
        if (!pr_err) begin
            if (pr_lines >= CNT_MAX) begin
                pr_err = 1'b1;
            end else begin
                pr_lines++;
            end
        end
        pr_cur = 0;
        pr_open = 1'b0;
    endfunction

    function automatic void num_byte(logic [7:0] c);
        logic [63:0] v;
        if (c == CH_MINUS && !pr_dig && !pr_neg) begin
            pr_neg = 1'b1;
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            if (pr_dig && pr_lz) begin
                pr_err = 1'b1;
                return;
            end
            if (!pr_dig && c == CH_ZERO) begin
                pr_lz = 1'b1;
            end
            pr_dig = 1'b1;
            v = 64'(pr_mag) * 64'd10 + 64'(c - CH_ZERO);
            if (v > 64'h8000_0000) begin
                pr_err = 1'b1;
            end else begin
                pr_mag = v[31:0];
            end
        end else if (c == CH_COMMA) begin
            num_check();
            pr_phase = TP_COMMA;
        end else begin
            pr_err = 1'b1;
        end
    endfunction

    function automatic void colour_byte(logic [7:0] c);
        if (c == CH_COMMA) begin
            if (colour_len_bad(pr_hex)) begin
                pr_err = 1'b1;
            end
            pr_phase = TP_SKIP;
            return;
        end
        if (pr_hex >= 8 || (pr_hex == 0 && c != CH_ZERO) || (pr_hex == 1 && c != CH_X) ||
            (pr_hex >= 2 && !is_hex(c))) begin
            pr_err = 1'b1;
            return;
        end
        pr_hex++;
    endfunction

    function automatic void feed_byte(logic [7:0] c);
        if (c == CH_NL) begin
            line_close();
            return;
        end
        pr_open = 1'b1;
        if (c == CH_SPACE) begin
            tok_close();
            return;
        end
        case (pr_phase)
            TP_GAP: begin
                pr_phase = TP_NUM;
                num_byte(c);
            end
            TP_NUM: begin
                num_byte(c);
            end
            TP_COMMA: begin
                // extra commas before the colour are skipped
                if (c != CH_COMMA) begin
                    pr_phase = TP_COLOUR;
                    colour_byte(c);
                end
            end
            TP_COLOUR: begin
                colour_byte(c);
            end
            default: begin
            end
        endcase
    endfunction

    function automatic void predict_item(logic [7:0] c, logic has, logic eof);
        t_verdict v;
        if (has && !pr_err) begin
            feed_byte(c);
        end
        if (!eof) begin
            return;
        end
        if (pr_open && !pr_err) begin
            line_close();
        end
        v.ok = !pr_err && pr_lines > 0 && pr_first != 0;
        v.tpl = v.ok ? 16'(pr_first) : 16'd0;
        v.lines = 16'(pr_lines);
        verdict_q.push_back(v);
        map_clear();
    endfunction

    // ---------------- text building ----------------

    function automatic void add_str(string s);
        for (int k = 0; k < s.len(); k++) begin
            text_q.push_back(s[k]);
        end
    endfunction

    function automatic void add_number(bit allow_bad);
        longint v;
        int pick = $urandom_range(99);
        if (allow_bad && pick < 30) begin
            case ($urandom_range(6))
                0: add_str("-0");
                1: add_str($sformatf("0%0d", $urandom_range(1, 99)));
                2: add_str($sformatf("+%0d", $urandom_range(0, 99)));
                3: add_str("2147483648");
                4: add_str("-2147483649");
                5: add_str($sformatf("%0d%0d", $urandom, $urandom_range(10, 99)));
                default: add_str("-");
            endcase
            return;
        end
        case (pick % 5)
            0: v = 0;
            1: begin
                v = $urandom_range(999);
                if ($urandom_range(1)) begin
                    v = -v;
                end
            end
            2: v = longint'($signed($urandom));
            3: v = 2147483647;
            default: v = -2147483648;
        endcase
        add_str($sformatf("%0d", v));
    endfunction

    function automatic void add_colour(bit allow_bad);
        int n;
        int d;
        logic [7:0] b;
        add_str(",");
        if ($urandom_range(3) == 0) begin
            add_str(",");
        end
        if ($urandom_range(9) == 0) begin
            return;
        end
        if (allow_bad && $urandom_range(2) == 0) begin
            n = $urandom_range(0, 7);
        end else begin
            n = 2 * $urandom_range(1, 3);
        end
        if (allow_bad && $urandom_range(5) == 0) begin
            if ($urandom_range(1)) begin
                add_str("0X");
            end else begin
                add_str("1x");
            end
        end else begin
            add_str("0x");
        end
        repeat (n) begin
            d = $urandom_range(15);
            if (d < 10) begin
                text_q.push_back(CH_ZERO + 8'(d));
            end else if ($urandom_range(1)) begin
                text_q.push_back(CH_LA + 8'(d - 10));
            end else begin
                text_q.push_back(CH_UA + 8'(d - 10));
            end
        end
        if ($urandom_range(3) == 0) begin
            add_str(",");
            // anything but separators is ignored here
            repeat ($urandom_range(0, 3)) begin
                b = 8'($urandom_range(255));
                if (b == CH_SPACE || b == CH_NL) begin
                    b = CH_TILDE;
                end
                text_q.push_back(b);
            end
        end
    endfunction

    function automatic void add_token(bit allow_bad);
        add_number(allow_bad);
        if ($urandom_range(99) < 40) begin
            add_colour(allow_bad);
        end
    endfunction

    function automatic void build_map();
        int rows = $urandom_range(1, 4);
        int cols = $urandom_range(1, 4);
        int flaw = $urandom_range(99);
        bit bad_tok = (flaw >= 55 && flaw < 70);
        int nt;
        for (int r = 0; r < rows; r++) begin
            nt = cols;
            if (flaw < 10 && r == rows - 1 && rows > 1) begin
                nt = $urandom_range(1) ? cols + 1 : cols - 1;
            end
            if ($urandom_range(7) == 0) begin
                add_str(" ");
            end
            for (int t = 0; t < nt; t++) begin
                if (t > 0) begin
                    if ($urandom_range(3) == 0) begin
                        add_str("  ");
                    end else begin
                        add_str(" ");
                    end
                end
                add_token(bad_tok && $urandom_range(3) == 0);
            end
            if ($urandom_range(5) == 0) begin
                add_str(" ");
            end
            if (r < rows - 1 || $urandom_range(1)) begin
                add_str("\n");
            end
        end
        if (flaw >= 70 && flaw < 80) begin
            text_q.insert($urandom_range(text_q.size()), 8'($urandom_range(255)));
        end
    endfunction

    // turns the built text into items; a bare end marker closes it when asked or when the text is empty
    task automatic queue_text(bit bare_end);
        t_byte_item it;
        for (int k = 0; k < text_q.size(); k++) begin
            if ($urandom_range(99) < 4) begin
                it.code = 8'($urandom);
                it.has = 1'b0;
                it.eof = 1'b0;
                pending_q.push_back(it);
            end
            it.code = text_q[k];
            it.has = 1'b1;
            it.eof = !bare_end && (k == text_q.size() - 1);
            pending_q.push_back(it);
        end
        if (bare_end || text_q.size() == 0) begin
            it.code = 8'($urandom);
            it.has = 1'b0;
            it.eof = 1'b1;
            pending_q.push_back(it);
        end
        bytes_queued += text_q.size();
        texts_queued++;
        text_q.delete();
    endtask

    task automatic wait_drain();
        while (pending_q.size() != 0 || i_valid || verdict_q.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    task automatic random_phase(int s_pct, int r_pct);
        int b0 = bytes_queued;
        int t0 = texts_queued;
        send_idle_pct = s_pct;
        stall_pct = r_pct;
        while (bytes_queued - b0 < 100 || texts_queued - t0 < 2) begin
            if ($urandom_range(99) < 8) begin
                repeat ($urandom_range(1, 8)) begin
                    text_q.push_back(8'($urandom_range(255)));
                end
            end else begin
                build_map();
            end
            queue_text($urandom_range(99) < 30);
        end
        wait_drain();
    endtask

    // ---------------- driver ----------------

    always @(posedge i_clk) begin
        t_byte_item nxt;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_item(i_char_code, i_has_char, i_end_of_file);
                items_accepted++;
            end
            if (!(i_valid && !o_ready)) begin
                if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = pending_q.pop_front();
                    i_valid <= 1'b1;
                    i_char_code <= nxt.code;
                    i_has_char <= nxt.has;
                    i_end_of_file <= nxt.eof;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served++;
            hold_left = HOLD_CYCLES;
            i_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // ---------------- monitor ----------------

    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (verdict_q.size() == 0) begin
                flag("result with no item pending");
            end else begin
                want = verdict_q.pop_front();
                if (o_map_ok !== want.ok) begin
                    flag($sformatf("map_ok %0b, want %0b", o_map_ok, want.ok));
                end
                if (o_tokens_per_line !== want.tpl) begin
                    flag($sformatf("tokens_per_line %0d, want %0d", o_tokens_per_line, want.tpl));
                end
                if (o_line_count !== want.lines) begin
                    flag($sformatf("line_count %0d, want %0d", o_line_count, want.lines));
                end
            end
        end
    end

    initial begin
        #20_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        t_byte_item noop;
        map_clear();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed texts, no idling
        queue_text(1'b1);                 // empty file
        add_str("\n \n");                 // first line holds no tokens
        queue_text(1'b1);
        noop.code = 8'hFF;
        noop.has = 1'b0;
        noop.eof = 1'b0;
        pending_q.push_back(noop);
        add_str("1 2\n3 4");              // last line has no newline
        queue_text(1'b0);
        add_str("5\n-0\n");               // error freezes the counts
        queue_text(1'b0);
        add_str(",5");                    // empty number part
        queue_text(1'b0);
        add_str("-12,,0xaB,");            // skipped commas, ignored tail
        text_q.push_back(8'hFF);
        add_str("\n");
        queue_text(1'b0);
        add_str("+1");
        queue_text(1'b0);
        add_str("1");
        text_q.push_back(8'h00);          // byte zero
        queue_text(1'b0);
        wait_drain();

        random_phase(0, 0);

        random_phase(56, 0);

        // long output stall while the sender keeps offering short maps
        stall_pct = 56;
        hold_requests++;
        repeat (12) begin
            add_str("1 2\n3 4\n");
            queue_text(1'b0);
        end
        random_phase(0, 56);

        random_phase(21, 21);

        repeat (10) @(negedge i_clk);
        $display("covered %0d texts, %0d items accepted, %0d results checked",
                 texts_queued, items_accepted, results_seen);
        $display("idle patterns: none, sender, receiver, both; one long output stall");
        if (errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

### files.f
design/hmtv_pkg.sv
design/hmtv_front.sv
design/hmtv_back.sv
design/height_map_text_validator.sv
test/height_map_text_validator_tb.sv
